// ----- hw/rtl/mtg_pkg.sv -----
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and word functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS + 1);

    typedef logic [31:0]       word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam addr_t WORDS_A   = addr_t'(STATE_WORDS);
    localparam addr_t LAST_A    = addr_t'(STATE_WORDS - 1);
    localparam addr_t OFFSET_A  = addr_t'(SHIFT_OFFSET);
    localparam addr_t WRAP_A    = addr_t'(STATE_WORDS - SHIFT_OFFSET);

    localparam word_t TWIST_MATRIX  = 32'h9908_b0df;
    localparam word_t HIGH_BIT      = 32'h8000_0000;
    localparam word_t LOW_BITS      = 32'h7fff_ffff;
    localparam word_t TEMPER_B      = 32'h9d2c_5680;
    localparam word_t TEMPER_C      = 32'hefc6_0000;
    localparam word_t SEED_MULT     = 32'd69069;
    localparam word_t SEED_AT_RESET = 32'd4357;

    function automatic word_t twist_word(input word_t cur, input word_t nxt,
                                         input word_t far_word);
        word_t y;
        y = (cur & HIGH_BIT) | (nxt & LOW_BITS);
        return far_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    endfunction

    function automatic word_t temper(input word_t w);
        word_t y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- hw/rtl/mtg_seed_gen.sv -----
// ----------------------------------------------------------------------------
// mtg_seed_gen
// Seeding sequencer: emits one table word per cycle, each 69069 times the last.
// ----------------------------------------------------------------------------
module mtg_seed_gen
    import mtg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  word_t seed,
    output logic  active,
    output logic  done,
    output addr_t wr_addr,
    output word_t wr_data
);

    logic  active_reg, active_next;
    addr_t cnt_reg, cnt_next;
    word_t word_reg, word_next;

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        if (start)
        begin
            active_next = 1'b1;
            cnt_next    = '0;
            word_next   = seed;
        end
        else if (active_reg)
        begin
            word_next = word_t'(word_reg * SEED_MULT);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_A)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            cnt_reg    <= '0;
            word_reg   <= SEED_AT_RESET;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            word_reg   <= word_next;
        end
    end

    assign active  = active_reg;
    assign done    = active_reg && (cnt_reg == LAST_A);
    assign wr_addr = cnt_reg;
    assign wr_data = word_reg;

endmodule

// ----- hw/rtl/mtg_out_stage.sv -----
// ----------------------------------------------------------------------------
// mtg_out_stage
// Tempering and output register of the result channel.
// ----------------------------------------------------------------------------
module mtg_out_stage
    import mtg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  word_t raw_word,
    output logic  free,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output word_t random_word
);

    logic  valid_reg, valid_next;
    word_t data_reg;

    assign free = !valid_reg || rsp_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= temper(raw_word);
        end
    end

    assign rsp_valid   = valid_reg;
    assign random_word = data_reg;

endmodule

// ----- hw/rtl/mt19937_generator_core.sv -----
// ----------------------------------------------------------------------------
// mt19937_generator_core
// MT19937 generator: 624-word state table in a two-read, one-write memory.
//
// Channels: a request beat (req_valid/req_ready, restart) asks for one word;
// each request yields exactly one response beat (rsp_valid/rsp_ready,
// random_word). A beat on the seed channel (seed_valid/seed_ready,
// seed_value) sets the seed used by the next restart; the table is untouched.
// Flow: a plain draw reads its word from the table in DRAW and loads it into
// the output register in OUT once the output slot is free; the block takes the
// next request once back in IDLE, so no new request is taken before the last
// word is loaded. Every 624th draw first twists the table, one word per cycle
// through the memory's two read ports. A restart first refills the table, one
// word per cycle, then twists it. Reset: the table is seeded from 4357;
// req_ready stays low meanwhile. A stalled receiver holds the response; one
// further request is taken and its word waits in the memory read until the slot frees.
// ----------------------------------------------------------------------------
module mt19937_generator_core
    import mtg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        restart,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [31:0] random_word,
    input  logic        seed_valid,
    output logic        seed_ready,
    input  logic [31:0] seed_value
);

    localparam logic [2:0] S_FILL     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DRAW     = 3'd2;
    localparam logic [2:0] S_TW_PRIME = 3'd3;
    localparam logic [2:0] S_TW_LOAD  = 3'd4;
    localparam logic [2:0] S_TW_RUN   = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       pend_reg, pend_next;
    addr_t      idx_reg, idx_next;
    addr_t      k_reg, k_next;
    word_t      cur_reg, cur_next;
    word_t      seed_reg;

    word_t      table_mem [STATE_WORDS];
    addr_t      rd_a_addr, rd_b_addr, wr_addr;
    word_t      rd_a_data, rd_b_data, wr_data;
    logic       wr_en;

    logic       seed_start, seed_active, seed_done;
    addr_t      seed_addr;
    word_t      seed_word;
    logic       out_load, out_free;

    addr_t      k1, k2, far1;
    logic       req_beat;

    mtg_seed_gen u_seed (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (seed_start),
        .seed    (seed_reg),
        .active  (seed_active),
        .done    (seed_done),
        .wr_addr (seed_addr),
        .wr_data (seed_word)
    );

    mtg_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .raw_word    (rd_a_data),
        .free        (out_free),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .random_word (random_word)
    );

    assign seed_ready = 1'b1;
    assign req_ready  = (state_reg == S_IDLE);
    assign req_beat   = req_valid && req_ready;

    // next-word addressing for the twist pipeline
    assign k1   = k_reg + 1'b1;
    assign k2   = (k1 == LAST_A) ? '0 : k1 + 1'b1;
    assign far1 = (k1 < WRAP_A) ? k1 + OFFSET_A : k1 - WRAP_A;

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        cur_next   = cur_reg;
        seed_start = 1'b0;
        out_load   = 1'b0;
        rd_a_addr  = idx_reg;
        rd_b_addr  = OFFSET_A;
        wr_en      = seed_active;
        wr_addr    = seed_addr;
        wr_data    = seed_word;

        unique case (state_reg)
            S_FILL:
            begin
                if (seed_done)
                begin
                    idx_next   = WORDS_A;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_DRAW : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_beat)
                begin
                    if (restart)
                    begin
                        seed_start = 1'b1;
                        pend_next  = 1'b1;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
            end
            S_DRAW:
            begin
                if (idx_reg >= WORDS_A)
                begin
                    state_next = S_TW_PRIME;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_TW_PRIME:
            begin
                rd_a_addr  = '0;
                state_next = S_TW_LOAD;
            end
            S_TW_LOAD:
            begin
                rd_a_addr  = addr_t'(1);
                rd_b_addr  = OFFSET_A;
                cur_next   = rd_a_data;
                k_next     = '0;
                state_next = S_TW_RUN;
            end
            S_TW_RUN:
            begin
                wr_en     = 1'b1;
                wr_addr   = k_reg;
                wr_data   = twist_word(cur_reg, rd_a_data, rd_b_data);
                cur_next  = rd_a_data;
                rd_a_addr = k2;
                rd_b_addr = far1;
                if (k_reg == LAST_A)
                begin
                    idx_next   = '0;
                    state_next = S_DRAW;
                end
                else
                begin
                    k_next = k1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL;
            pend_reg  <= 1'b0;
            idx_reg   <= WORDS_A;
            k_reg     <= '0;
            seed_reg  <= SEED_AT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
            if (seed_valid && seed_ready)
            begin
                seed_reg <= seed_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_a_data <= table_mem[rd_a_addr];
        rd_b_data <= table_mem[rd_b_addr];
    end

endmodule
